FILE: hdl/ewft_pkg.sv
// Shared types, constants and saturating helpers for the edge wind force/torque block.
// Used by every module of the block but ewft_delay; depends on nothing.
package ewft_pkg;

   localparam int MAX_QUAD_POINTS = 16;
   localparam int NQ_W            = 5;
   localparam int CSR_IDX_W       = 3;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QP_W            = $clog2(QUEUE_DEPTH);
   localparam int FMUL_LAT        = 5;
   localparam int SQRT_LAT        = 32;

   typedef logic signed [63:0] fx_type;

   localparam fx_type FX_MAX = {1'b0, {63{1'b1}}};
   localparam fx_type FX_MIN = {1'b1, {63{1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRAG_GAIN = 3'd0,
      CSR_WIND_X    = 3'd1,
      CSR_WIND_Y    = 3'd2,
      CSR_NUM_QUAD  = 3'd3
   } csr_index_type;

   // One classified edge, as it waits between front and back
   typedef struct packed {
      logic              degenerate;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [32:0] ddx;
      logic signed [32:0] ddy;
      logic signed [32:0] ux;
      logic signed [32:0] uy;
      logic signed [31:0] w;
      logic [NQ_W-1:0]    nq;
   } edge_item_type;

   function automatic fx_type sat_add(fx_type a, fx_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
      return s[63:0];
   endfunction

   function automatic fx_type sat_sub(fx_type a, fx_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
      return s[63:0];
   endfunction

   function automatic logic [63:0] magnitude(fx_type a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   // Apply sign to an unsigned quotient/product, floor towards minus infinity, saturate
   function automatic fx_type sat_finish(logic [127:0] q, logic neg, logic inexact);
      logic [127:0] qn;
      qn = q + {127'd0, inexact};
      if (!neg) return (|q[127:63]) ? FX_MAX : fx_type'(q[63:0]);
      if (|qn[127:63]) return FX_MIN;
      return -fx_type'(qn[63:0]);
   endfunction

   function automatic logic [47:0] sat48(fx_type v);
      if ((&v[63:47]) || !(|v[63:47])) return v[47:0];
      return v[63] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
   endfunction

endpackage

FILE: hdl/ewft_if.sv
// Channel interfaces of the edge wind force/torque block: request, response, register write.
// Depends on nothing.
interface ewft_req_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] edge_start_x;
   logic signed [31:0] edge_start_y;
   logic signed [31:0] edge_dx;
   logic signed [31:0] edge_dy;
   logic signed [31:0] center_x;
   logic signed [31:0] center_y;
   logic signed [31:0] body_vel_x;
   logic signed [31:0] body_vel_y;
   logic signed [31:0] spin_rate;

   modport source (output valid, edge_start_x, edge_start_y, edge_dx, edge_dy, center_x,
                   center_y, body_vel_x, body_vel_y, spin_rate, input ready);
   modport sink (input valid, edge_start_x, edge_start_y, edge_dx, edge_dy, center_x,
                 center_y, body_vel_x, body_vel_y, spin_rate, output ready);
endinterface

interface ewft_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [47:0] force_x;
   logic signed [47:0] force_y;
   logic signed [47:0] torque_z;
   logic              degenerate_edge;

   modport source (output valid, force_x, force_y, torque_z, degenerate_edge, input ready);
   modport sink (input valid, force_x, force_y, torque_z, degenerate_edge, output ready);
endinterface

interface ewft_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/ewft_delay.sv
// Enabled shift line that aligns operands across the back pipeline.
// No dependencies.
module ewft_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] sr_ff [DEPTH];

   // advance the line on enable
   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign q = sr_ff[DEPTH-1];

endmodule

FILE: hdl/ewft_fmul.sv
// Pipelined signed fixed-point multiply: 64x64 from four 32x32 partial products,
// floored to FRAC_BITS and saturated to 64 bits. Depends on ewft_pkg.
module ewft_fmul #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            en,
   input  ewft_pkg::fx_type a,
   input  ewft_pkg::fx_type b,
   output ewft_pkg::fx_type p
);

   localparam logic [127:0] FRAC_MASK = (128'd1 << FRAC_BITS) - 128'd1;

   logic [63:0]  ua_ff, ub_ff;
   logic         neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [63:0]  p0_ff, p1_ff, p2_ff, p3_ff;
   logic [63:0]  lo3_ff, hi3_ff;
   logic [64:0]  mid_ff;
   logic [127:0] prod_ff, prod_in, q_shift;
   ewft_pkg::fx_type p_ff;

   assign prod_in = {hi3_ff, lo3_ff} + {31'd0, mid_ff, 32'd0};
   assign q_shift = prod_ff >> FRAC_BITS;

   // magnitudes, partial products, middle sum, full product, rounding
   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ewft_pkg::magnitude(a);
         ub_ff   <= ewft_pkg::magnitude(b);
         neg1_ff <= a[63] ^ b[63];

         p0_ff   <= ua_ff[31:0]  * ub_ff[31:0];
         p1_ff   <= ua_ff[31:0]  * ub_ff[63:32];
         p2_ff   <= ua_ff[63:32] * ub_ff[31:0];
         p3_ff   <= ua_ff[63:32] * ub_ff[63:32];
         neg2_ff <= neg1_ff;

         mid_ff  <= {1'b0, p1_ff} + {1'b0, p2_ff};
         lo3_ff  <= p0_ff;
         hi3_ff  <= p3_ff;
         neg3_ff <= neg2_ff;

         prod_ff <= prod_in;
         neg4_ff <= neg3_ff;

         p_ff    <= ewft_pkg::sat_finish(q_shift, neg4_ff, |(prod_ff & FRAC_MASK));
      end
   end

   assign p = p_ff;

endmodule

FILE: hdl/ewft_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on ewft_pkg.
module ewft_isqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] v,
   output logic [31:0] r
);

   logic [63:0] v_ff [ewft_pkg::SQRT_LAT];
   logic [63:0] r_ff [ewft_pkg::SQRT_LAT];

   for (genvar k = 0; k < ewft_pkg::SQRT_LAT; k++) begin : g_stage
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] v_src, r_src, trial;
      logic        fits;

      if (k == 0) begin : g_first
         assign v_src = v;
         assign r_src = 64'd0;
      end else begin : g_next
         assign v_src = v_ff[k-1];
         assign r_src = r_ff[k-1];
      end

      assign trial = r_src + BIT;
      assign fits  = v_src >= trial;

      // take one root bit
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k] <= fits ? v_src - trial : v_src;
            r_ff[k] <= fits ? (r_src >> 1) + BIT : r_src >> 1;
         end
      end
   end

   assign r = r_ff[ewft_pkg::SQRT_LAT-1][31:0];

endmodule

FILE: hdl/ewft_fdiv.sv
// Pipelined restoring divider: floor(a * 2^FRAC_BITS / b), saturated to 64 bits,
// one quotient bit per stage. Depends on ewft_pkg.
module ewft_fdiv #(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            en,
   input  ewft_pkg::fx_type a,
   input  logic [31:0]     b,
   output ewft_pkg::fx_type q
);

   localparam int NW = 64 + FRAC_BITS;

   logic [NW-1:0] nq0_ff;
   logic [31:0]   b0_ff;
   logic          neg0_ff;
   logic [NW-1:0] nq_ff  [NW];
   logic [31:0]   rem_ff [NW];
   logic [31:0]   b_ff   [NW];
   logic          neg_ff [NW];
   ewft_pkg::fx_type q_ff;

   // register the scaled numerator magnitude
   always_ff @(posedge clock) begin
      if (en) begin
         nq0_ff  <= {ewft_pkg::magnitude(a), {FRAC_BITS{1'b0}}};
         b0_ff   <= b;
         neg0_ff <= a[63];
      end
   end

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [NW-1:0] nq_src;
      logic [31:0]   rem_src, b_src;
      logic          neg_src, fits;
      logic [32:0]   rem2;

      if (k == 0) begin : g_first
         assign nq_src  = nq0_ff;
         assign rem_src = 32'd0;
         assign b_src   = b0_ff;
         assign neg_src = neg0_ff;
      end else begin : g_next
         assign nq_src  = nq_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign b_src   = b_ff[k-1];
         assign neg_src = neg_ff[k-1];
      end

      assign rem2 = {rem_src, nq_src[NW-1]};
      assign fits = rem2 >= {1'b0, b_src};

      // shift in one quotient bit
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= fits ? 32'(rem2 - {1'b0, b_src}) : rem2[31:0];
            nq_ff[k]  <= {nq_src[NW-2:0], fits};
            b_ff[k]   <= b_src;
            neg_ff[k] <= neg_src;
         end
      end
   end

   // sign, floor and saturate
   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= ewft_pkg::sat_finish(128'(nq_ff[NW-1]), neg_ff[NW-1], |rem_ff[NW-1]);
      end
   end

   assign q = q_ff;

endmodule

FILE: hdl/ewft_front.sv
// Front end: takes edges, forms offsets, relative wind and the zero-length flag,
// and holds them in a short queue for the back end. Depends on ewft_pkg, ewft_if.
module ewft_front (
   input  logic                       clock,
   input  logic                       reset,
   ewft_req_if.sink                   req,
   input  logic signed [31:0]         wind_x,
   input  logic signed [31:0]         wind_y,
   input  logic [ewft_pkg::NQ_W-1:0]  nq,
   input  logic                       pop,
   output ewft_pkg::edge_item_type    item,
   output logic                       item_valid
);

   ewft_pkg::edge_item_type q_mem [ewft_pkg::QUEUE_DEPTH];
   ewft_pkg::edge_item_type item_in;
   logic [ewft_pkg::QP_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [ewft_pkg::QP_W:0]   count_ff, count_in;
   logic push;

   // classify the incoming edge
   always_comb begin
      item_in.degenerate = (req.edge_dx == 32'sd0) && (req.edge_dy == 32'sd0);
      item_in.dx  = req.edge_dx;
      item_in.dy  = req.edge_dy;
      item_in.ddx = {req.edge_start_x[31], req.edge_start_x} - {req.center_x[31], req.center_x};
      item_in.ddy = {req.edge_start_y[31], req.edge_start_y} - {req.center_y[31], req.center_y};
      item_in.ux  = {wind_x[31], wind_x} - {req.body_vel_x[31], req.body_vel_x};
      item_in.uy  = {wind_y[31], wind_y} - {req.body_vel_y[31], req.body_vel_y};
      item_in.w   = req.spin_rate;
      item_in.nq  = nq;
   end

   assign req.ready  = count_ff != (ewft_pkg::QP_W+1)'(ewft_pkg::QUEUE_DEPTH);
   assign push       = req.valid && req.ready;
   assign item_valid = count_ff != '0;
   assign item       = q_mem[rd_ptr_ff];
   assign count_in   = count_ff + {{ewft_pkg::QP_W{1'b0}}, push}
                                - {{ewft_pkg::QP_W{1'b0}}, pop};

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= item_in;
      end
   end

   // queue pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

FILE: hdl/ewft_back.sv
// Back end: closed-form quadrature of the drag law through multiply, root and divide pipes,
// with the result register. Depends on ewft_pkg, ewft_if, ewft_delay and the arithmetic units.
module ewft_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ewft_pkg::edge_item_type item,
   input  logic                    item_valid,
   output logic                    pop,
   input  logic [30:0]             drag_gain,
   ewft_rsp_if.source              rsp
);

   localparam int M       = ewft_pkg::FMUL_LAT;
   localparam int DIV_LAT = 64 + FRAC_BITS + 2;
   localparam int T_LRAW  = 2;
   localparam int T_AB    = M + 1;
   localparam int T_G     = T_AB + 1;
   localparam int T_WG    = T_G + M;
   localparam int T_S     = T_WG + 1;
   localparam int T_KN    = T_S + M;
   localparam int T_P     = T_KN + 1;
   localparam int T_TN    = T_P + M;
   localparam int T_L     = T_LRAW + ewft_pkg::SQRT_LAT;
   localparam int T_DIV   = T_L + DIV_LAT;
   localparam int T_FK    = T_DIV + M;
   localparam int T_OUT   = T_FK + 1;

   logic adv;
   logic [T_OUT:0] vld_ff;
   ewft_pkg::edge_item_type it_ff;
   logic signed [63:0] sqx_ff, sqy_ff;
   logic [63:0] lraw_ff;
   ewft_pkg::fx_type dx64, dy64, ndy64, ddx64, ddy64, ux64, uy64, beta64;
   ewft_pkg::fx_type l2, l2h, l2_d, l2h_d;
   ewft_pkg::fx_type a1, a2, b1, b2, a_ff, b_ff, a_d1, b_d1, a_d6, ag_d;
   ewft_pkg::fx_type g_ff, bl_ff, s_ff, q_ff, p_ff;
   logic signed [31:0] w_g, w_q, dx_f, dy_f;
   ewft_pkg::fx_type w_g64, w_q64, dxf64, ndyf64;
   logic [ewft_pkg::NQ_W-1:0] nq_g;
   logic [FRAC_BITS-1:0] cn_tab [2**ewft_pkg::NQ_W];
   ewft_pkg::fx_type cn64;
   ewft_pkg::fx_type wg, ll, llc, bbl, ag, wq, kn, tn, kn_d, tn_d, k_q, t_q, t_d;
   ewft_pkg::fx_type fx_p, fy_p;
   logic [31:0] len;
   logic deg_d;
   logic signed [47:0] force_x_ff, force_y_ff, torque_z_ff;
   logic degenerate_ff;

   // hold everything while a result waits
   assign adv = !vld_ff[T_OUT] || rsp.ready;
   assign pop = adv && item_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[T_OUT-1:0], pop};
      end
   end

   // quadrature factor c(N), fixed per count at elaboration
   for (genvar g = 0; g < 2**ewft_pkg::NQ_W; g++) begin : g_cn
      localparam longint GE = (g < 2) ? 2 :
                              ((g > ewft_pkg::MAX_QUAD_POINTS) ? ewft_pkg::MAX_QUAD_POINTS : g);
      localparam longint CNV = ((4 * GE * GE - 1) << FRAC_BITS) / (12 * GE * GE);
      assign cn_tab[g] = CNV[FRAC_BITS-1:0];
   end

   // take item, square the edge, sum the squares
   always_ff @(posedge clock) begin
      if (adv) begin
         it_ff   <= item;
         sqx_ff  <= it_ff.dx * it_ff.dx;
         sqy_ff  <= it_ff.dy * it_ff.dy;
         lraw_ff <= sqx_ff + sqy_ff;
      end
   end

   assign dx64   = {{32{it_ff.dx[31]}}, it_ff.dx};
   assign dy64   = {{32{it_ff.dy[31]}}, it_ff.dy};
   assign ndy64  = -dy64;
   assign ddx64  = {{31{it_ff.ddx[32]}}, it_ff.ddx};
   assign ddy64  = {{31{it_ff.ddy[32]}}, it_ff.ddy};
   assign ux64   = {{31{it_ff.ux[32]}}, it_ff.ux};
   assign uy64   = {{31{it_ff.uy[32]}}, it_ff.uy};
   assign beta64 = {33'd0, drag_gain};
   assign l2     = ewft_pkg::fx_type'(lraw_ff >> FRAC_BITS);
   assign l2h    = ewft_pkg::fx_type'(lraw_ff >> (FRAC_BITS + 1));

   // normal projection of the wind and edge projection of the offset
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a1 (.clock, .en(adv), .a(ndy64), .b(ux64), .p(a1));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_a2 (.clock, .en(adv), .a(dx64), .b(uy64), .p(a2));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b1 (.clock, .en(adv), .a(dx64), .b(ddx64), .p(b1));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_b2 (.clock, .en(adv), .a(dy64), .b(ddy64), .p(b2));

   ewft_delay #(.WIDTH(64), .DEPTH(T_AB - T_LRAW)) u_dly_l2
      (.clock, .en(adv), .d(l2), .q(l2_d));
   ewft_delay #(.WIDTH(64), .DEPTH(T_AB - T_LRAW)) u_dly_l2h
      (.clock, .en(adv), .d(l2h), .q(l2h_d));
   ewft_delay #(.WIDTH(32), .DEPTH(T_G)) u_dly_wg
      (.clock, .en(adv), .d(it_ff.w), .q(w_g));
   ewft_delay #(.WIDTH(32), .DEPTH(T_S)) u_dly_wq
      (.clock, .en(adv), .d(it_ff.w), .q(w_q));
   ewft_delay #(.WIDTH(ewft_pkg::NQ_W), .DEPTH(T_G)) u_dly_nq
      (.clock, .en(adv), .d(it_ff.nq), .q(nq_g));

   // combine projections, centre offset terms
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= ewft_pkg::sat_add(a1, a2);
         b_ff  <= ewft_pkg::sat_add(b1, b2);
         g_ff  <= ewft_pkg::sat_add(b_ff, l2h_d);
         bl_ff <= ewft_pkg::sat_add(b_ff, l2_d);
      end
   end

   ewft_delay #(.WIDTH(64), .DEPTH(1)) u_dly_a1 (.clock, .en(adv), .d(a_ff), .q(a_d1));
   ewft_delay #(.WIDTH(64), .DEPTH(1)) u_dly_b1 (.clock, .en(adv), .d(b_ff), .q(b_d1));
   ewft_delay #(.WIDTH(64), .DEPTH(T_WG - T_AB)) u_dly_a6
      (.clock, .en(adv), .d(a_ff), .q(a_d6));

   assign w_g64 = {{32{w_g[31]}}, w_g};
   assign w_q64 = {{32{w_q[31]}}, w_q};
   assign cn64  = {{(64 - FRAC_BITS){1'b0}}, cn_tab[nq_g]};

   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_wg  (.clock, .en(adv), .a(w_g64), .b(g_ff), .p(wg));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ll  (.clock, .en(adv), .a(l2), .b(l2), .p(ll));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_llc (.clock, .en(adv), .a(ll), .b(cn64), .p(llc));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_bbl (.clock, .en(adv), .a(b_d1), .b(bl_ff), .p(bbl));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ag  (.clock, .en(adv), .a(a_d1), .b(g_ff), .p(ag));

   ewft_delay #(.WIDTH(64), .DEPTH(T_KN - T_WG)) u_dly_ag
      (.clock, .en(adv), .d(ag), .q(ag_d));

   // net normal speed and second-moment term
   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff <= ewft_pkg::sat_sub(a_d6, wg);
         q_ff <= ewft_pkg::sat_add(bbl, llc);
         p_ff <= ewft_pkg::sat_sub(ag_d, wq);
      end
   end

   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_kn (.clock, .en(adv), .a(beta64), .b(s_ff), .p(kn));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_wq (.clock, .en(adv), .a(w_q64), .b(q_ff), .p(wq));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_tn (.clock, .en(adv), .a(beta64), .b(p_ff), .p(tn));

   // edge length
   ewft_isqrt u_sqrt (.clock, .en(adv), .v(lraw_ff), .r(len));

   ewft_delay #(.WIDTH(64), .DEPTH(T_L - T_KN)) u_dly_kn
      (.clock, .en(adv), .d(kn), .q(kn_d));
   ewft_delay #(.WIDTH(64), .DEPTH(T_L - T_TN)) u_dly_tn
      (.clock, .en(adv), .d(tn), .q(tn_d));

   ewft_fdiv #(.FRAC_BITS(FRAC_BITS)) u_div_k (.clock, .en(adv), .a(kn_d), .b(len), .q(k_q));
   ewft_fdiv #(.FRAC_BITS(FRAC_BITS)) u_div_t (.clock, .en(adv), .a(tn_d), .b(len), .q(t_q));

   ewft_delay #(.WIDTH(32), .DEPTH(T_DIV)) u_dly_dx
      (.clock, .en(adv), .d(it_ff.dx), .q(dx_f));
   ewft_delay #(.WIDTH(32), .DEPTH(T_DIV)) u_dly_dy
      (.clock, .en(adv), .d(it_ff.dy), .q(dy_f));
   ewft_delay #(.WIDTH(1), .DEPTH(T_FK)) u_dly_deg
      (.clock, .en(adv), .d(it_ff.degenerate), .q(deg_d));
   ewft_delay #(.WIDTH(64), .DEPTH(M)) u_dly_t
      (.clock, .en(adv), .d(t_q), .q(t_d));

   assign dxf64  = {{32{dx_f[31]}}, dx_f};
   assign ndyf64 = -{{32{dy_f[31]}}, dy_f};

   // force along the normal
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_fx (.clock, .en(adv), .a(k_q), .b(ndyf64), .p(fx_p));
   ewft_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul_fy (.clock, .en(adv), .a(k_q), .b(dxf64), .p(fy_p));

   // result register: clamp to 48 bits, zero out a degenerate edge
   always_ff @(posedge clock) begin
      if (adv) begin
         force_x_ff    <= deg_d ? '0 : ewft_pkg::sat48(fx_p);
         force_y_ff    <= deg_d ? '0 : ewft_pkg::sat48(fy_p);
         torque_z_ff   <= deg_d ? '0 : ewft_pkg::sat48(t_d);
         degenerate_ff <= deg_d;
      end
   end

   assign rsp.valid           = vld_ff[T_OUT];
   assign rsp.force_x         = force_x_ff;
   assign rsp.force_y         = force_y_ff;
   assign rsp.torque_z        = torque_z_ff;
   assign rsp.degenerate_edge = degenerate_ff;

endmodule

FILE: hdl/edge_wind_force_torque.sv
// Wind drag force and torque on one rigid-body edge, Q16.16 in, Q32.16 saturated out.
// Throughput: one edge per cycle while responses are taken; every unit (multiplies, root,
//   divider) is fully pipelined. The longest path runs through the 32-stage square root
//   feeding the (64 + FRAC_BITS)-bit restoring divider.
// Reset: synchronous; empties the queue and pipeline, clears the wind and gain registers
//   and sets the quadrature count to 2.
module edge_wind_force_torque #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ewft_req_if.sink    req_chan,
   ewft_rsp_if.source  rsp_chan,
   ewft_csr_if.sink    csr_chan
);

   logic [30:0]               drag_gain_ff;
   logic signed [31:0]        wind_x_ff, wind_y_ff;
   logic [ewft_pkg::NQ_W-1:0] num_quad_ff;
   ewft_pkg::edge_item_type   item;
   logic item_valid, pop;

   assign csr_chan.ready = 1'b1;

   // register writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         drag_gain_ff <= '0;
         wind_x_ff    <= '0;
         wind_y_ff    <= '0;
         num_quad_ff  <= ewft_pkg::NQ_W'(2);
      end else if (csr_chan.valid) begin
         case (ewft_pkg::csr_index_type'(csr_chan.index))
            ewft_pkg::CSR_DRAG_GAIN: drag_gain_ff <= csr_chan.data[30:0];
            ewft_pkg::CSR_WIND_X:    wind_x_ff    <= csr_chan.data;
            ewft_pkg::CSR_WIND_Y:    wind_y_ff    <= csr_chan.data;
            ewft_pkg::CSR_NUM_QUAD:  num_quad_ff  <= csr_chan.data[ewft_pkg::NQ_W-1:0];
            default: ;
         endcase
      end
   end

   ewft_front u_front (
      .clock,
      .reset,
      .req        (req_chan),
      .wind_x     (wind_x_ff),
      .wind_y     (wind_y_ff),
      .nq         (num_quad_ff),
      .pop,
      .item,
      .item_valid
   );

   ewft_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock,
      .reset,
      .item,
      .item_valid,
      .pop,
      .drag_gain (drag_gain_ff),
      .rsp       (rsp_chan)
   );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the edge wind force/torque block: drives edges and register
// writes, predicts force and torque in 130-bit fixed point and checks every response.
// Depends on hdl/ewft_pkg.sv, hdl/ewft_if.sv and hdl/edge_wind_force_torque.sv.
module tb_top;

   localparam int          CYCLE_LIMIT    = 400000;
   localparam int          SETTLE_CYCLES  = 160;
   localparam int          IDLE_PERCENT   = 23;
   localparam int          GAP_PERCENT    = (IDLE_PERCENT * 100) / (100 - IDLE_PERCENT);
   localparam logic [2:0]  CSR_SPARE_IDX  = 3'd6;
   localparam logic [2:0]  CSR_TOP_IDX    = 3'd7;

   typedef struct {
      logic signed [31:0] start_x, start_y, dx, dy, cen_x, cen_y, vel_x, vel_y, spin;
   } seg_type;

   typedef struct {
      logic signed [47:0] fx, fy, tz;
      logic               degen;
   } load_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ewft_req_if req_chan ();
   ewft_rsp_if rsp_chan ();
   ewft_csr_if csr_chan ();

   edge_wind_force_torque dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   // shadow copy of the registers
   logic [30:0]        gain_reg = '0;
   logic signed [31:0] wind_x_reg = '0;
   logic signed [31:0] wind_y_reg = '0;
   logic [4:0]         nq_reg = 5'd2;

   load_type pending_loads[$];
   int       cycle_count = 0;
   int       fail_count = 0;
   int       sent_count = 0;
   int       checked_count = 0;
   int       degen_count = 0;
   int       csr_count = 0;
   bit       calm = 1'b0;
   bit       hold_rsp = 1'b0;

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- fixed-point helpers
   function automatic ewft_pkg::fx_type clip64(logic signed [129:0] v);
      if (v > 130'sh7FFF_FFFF_FFFF_FFFF) return ewft_pkg::FX_MAX;
      if (v < -130'sh8000_0000_0000_0000) return ewft_pkg::FX_MIN;
      return v[63:0];
   endfunction

   function automatic ewft_pkg::fx_type fx_mul(ewft_pkg::fx_type a, ewft_pkg::fx_type b);
      logic signed [129:0] wa, wb, p;
      wa = a;
      wb = b;
      p = wa * wb;
      return clip64(p >>> 16);
   endfunction

   // floor(a * 2^16 / b) for positive b
   function automatic ewft_pkg::fx_type fx_div(ewft_pkg::fx_type a, ewft_pkg::fx_type b);
      logic signed [129:0] num, den, q;
      if (b <= 0) return '0;
      num = a;
      num = num <<< 16;
      den = b;
      q = num / den;
      if (num < 0 && q * den != num) q = q - 1;
      return clip64(q);
   endfunction

   function automatic ewft_pkg::fx_type fx_add(ewft_pkg::fx_type a, ewft_pkg::fx_type b);
      logic signed [129:0] wa, wb;
      wa = a;
      wb = b;
      return clip64(wa + wb);
   endfunction

   function automatic ewft_pkg::fx_type fx_sub(ewft_pkg::fx_type a, ewft_pkg::fx_type b);
      logic signed [129:0] wa, wb;
      wa = a;
      wb = b;
      return clip64(wa - wb);
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [47:0] clamp48(ewft_pkg::fx_type v);
      if (v > 64'sh0000_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
      if (v < -64'sh0000_8000_0000_0000) return 48'sh8000_0000_0000;
      return v[47:0];
   endfunction

   // ---------------------------------------------------------------- drag predictor
   function automatic load_type wind_load(seg_type s);
      load_type         r;
      ewft_pkg::fx_type dx, dy, ddx, ddy, ux, uy, w, beta, len, sq, sqh, a, b, g, sv, k, q, p;
      logic [63:0]      raw, cn, n;
      dx = s.dx;
      dy = s.dy;
      r.degen = 1'b0;
      if (dx == 0 && dy == 0) begin
         r.fx = '0;
         r.fy = '0;
         r.tz = '0;
         r.degen = 1'b1;
         return r;
      end
      ddx = ewft_pkg::fx_type'(s.start_x) - ewft_pkg::fx_type'(s.cen_x);
      ddy = ewft_pkg::fx_type'(s.start_y) - ewft_pkg::fx_type'(s.cen_y);
      ux = ewft_pkg::fx_type'(wind_x_reg) - ewft_pkg::fx_type'(s.vel_x);
      uy = ewft_pkg::fx_type'(wind_y_reg) - ewft_pkg::fx_type'(s.vel_y);
      w = s.spin;
      beta = {33'd0, gain_reg};
      n = nq_reg;
      if (n < 2) n = 2;
      if (n > ewft_pkg::MAX_QUAD_POINTS) n = ewft_pkg::MAX_QUAD_POINTS;
      cn = ((4 * n * n - 1) << 16) / (12 * n * n);
      raw = dx * dx + dy * dy;
      len = root64(raw);
      sq = raw >> 16;
      sqh = raw >> 17;
      a = fx_add(fx_mul(-dy, ux), fx_mul(dx, uy));
      b = fx_add(fx_mul(dx, ddx), fx_mul(dy, ddy));
      g = fx_add(b, sqh);
      sv = fx_sub(a, fx_mul(w, g));
      k = fx_div(fx_mul(beta, sv), len);
      r.fx = clamp48(fx_mul(k, -dy));
      r.fy = clamp48(fx_mul(k, dx));
      q = fx_add(fx_mul(b, fx_add(b, sq)), fx_mul(fx_mul(sq, sq), ewft_pkg::fx_type'(cn)));
      p = fx_sub(fx_mul(a, g), fx_mul(w, q));
      r.tz = clamp48(fx_div(fx_mul(beta, p), len));
      return r;
   endfunction

   // ---------------------------------------------------------------- shared drivers
   task automatic send_seg(seg_type s);
      if (!calm && $urandom_range(99) < GAP_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.edge_start_x <= s.start_x;
      req_chan.edge_start_y <= s.start_y;
      req_chan.edge_dx      <= s.dx;
      req_chan.edge_dy      <= s.dy;
      req_chan.center_x     <= s.cen_x;
      req_chan.center_y     <= s.cen_y;
      req_chan.body_vel_x   <= s.vel_x;
      req_chan.body_vel_y   <= s.vel_y;
      req_chan.spin_rate    <= s.spin;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_loads.push_back(wind_load(s));
      sent_count++;
   endtask

   task automatic stop_sending();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every response, then let the pipeline settle
   task automatic drain();
      stop_sending();
      while (pending_loads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         ewft_pkg::CSR_DRAG_GAIN: gain_reg = value[30:0];
         ewft_pkg::CSR_WIND_X:    wind_x_reg = value;
         ewft_pkg::CSR_WIND_Y:    wind_y_reg = value;
         ewft_pkg::CSR_NUM_QUAD:  nq_reg = value[4:0];
         default: ;
      endcase
      csr_count++;
      csr_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_wind(logic [31:0] g, logic [31:0] wx, logic [31:0] wy, logic [31:0] n);
      write_reg(ewft_pkg::CSR_DRAG_GAIN, g);
      write_reg(ewft_pkg::CSR_WIND_X, wx);
      write_reg(ewft_pkg::CSR_WIND_Y, wy);
      write_reg(ewft_pkg::CSR_NUM_QUAD, n);
   endtask

   // mix of full-range, small, moderate and boundary values
   function automatic logic signed [31:0] pick32();
      case ($urandom_range(4))
         0, 1: return $urandom;
         2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         3: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
         default: begin
            case ($urandom_range(4))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
      endcase
   endfunction

   function automatic seg_type random_seg();
      seg_type s;
      s.start_x = pick32();
      s.start_y = pick32();
      s.dx      = pick32();
      s.dy      = pick32();
      s.cen_x   = pick32();
      s.cen_y   = pick32();
      s.vel_x   = pick32();
      s.vel_y   = pick32();
      s.spin    = pick32();
      if ($urandom_range(19) == 0) begin
         s.dx = '0;
         s.dy = '0;
      end
      return s;
   endfunction

   function automatic seg_type flat_seg(logic signed [31:0] v);
      seg_type s;
      s.start_x = v; s.start_y = v; s.dx = v; s.dy = v; s.cen_x = v;
      s.cen_y = v; s.vel_x = v; s.vel_y = v; s.spin = v;
      return s;
   endfunction

   // ---------------------------------------------------------------- response side
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // compare each response transfer against the oldest prediction
   always @(posedge clock) begin
      load_type exp_load;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_loads.size() == 0) begin
            $error("response with no prediction waiting");
            fail_count++;
         end else begin
            exp_load = pending_loads.pop_front();
            checked_count++;
            if (rsp_chan.degenerate_edge) degen_count++;
            if (rsp_chan.force_x !== exp_load.fx) begin
               $error("force_x: expected %0d, got %0d", exp_load.fx, rsp_chan.force_x);
               fail_count++;
            end
            if (rsp_chan.force_y !== exp_load.fy) begin
               $error("force_y: expected %0d, got %0d", exp_load.fy, rsp_chan.force_y);
               fail_count++;
            end
            if (rsp_chan.torque_z !== exp_load.tz) begin
               $error("torque_z: expected %0d, got %0d", exp_load.tz, rsp_chan.torque_z);
               fail_count++;
            end
            if (rsp_chan.degenerate_edge !== exp_load.degen) begin
               $error("degenerate_edge: expected %0b, got %0b", exp_load.degen,
                      rsp_chan.degenerate_edge);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      seg_type s;
      set_wind(32'h0001_0000, 32'h0003_0000, 32'hFFFE_0000, 32'd4);
      send_seg(flat_seg(32'sh7FFF_FFFF));
      send_seg(flat_seg(32'sh8000_0000));
      send_seg(flat_seg(32'sd0));
      send_seg(flat_seg(-32'sd1));
      send_seg(flat_seg(32'sd1));
      // zero-length edge with busy surroundings
      s = random_seg();
      s.dx = '0;
      s.dy = '0;
      send_seg(s);
      // axis-aligned edges, unit scale
      s = flat_seg(32'sd0);
      s.dx = 32'sh0001_0000;
      send_seg(s);
      s.dx = '0;
      s.dy = -32'sh0002_0000;
      send_seg(s);
      s.spin = 32'sh0000_8000;
      s.vel_x = 32'sh0004_0000;
      send_seg(s);
      // extremes mixed per field
      repeat (12) begin
         s.start_x = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.start_y = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.dx      = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.dy      = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.cen_x   = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.cen_y   = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.vel_x   = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.vel_y   = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.spin    = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         send_seg(s);
      end
      drain();
   endtask

   // sweep register extremes, out-of-range quadrature counts and unused indexes
   task automatic test_register_sweep();
      logic [31:0] counts[8] = '{32'd0, 32'd1, 32'd2, 32'd16, 32'd17, 32'd31, 32'hFFFF_FFE3, 32'd9};
      foreach (counts[i]) begin
         case (i % 4)
            0: set_wind(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, counts[i]);
            1: set_wind(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, counts[i]);
            2: set_wind(32'h0000_0000, 32'h0001_0000, 32'h0001_0000, counts[i]);
            default: set_wind($urandom, $urandom, $urandom, counts[i]);
         endcase
         write_reg(CSR_SPARE_IDX, $urandom);
         write_reg(CSR_TOP_IDX, $urandom);
         repeat (6) send_seg(random_seg());
         drain();
      end
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 6; ph++) begin
         calm = (ph == 1);
         set_wind($urandom, $urandom, $urandom, $urandom_range(0, 31));
         repeat (115) send_seg(random_seg());
         drain();
      end
      calm = 1'b0;
   endtask

   // stall the response side long enough for the block to fill and refuse requests
   task automatic test_backpressure();
      set_wind(32'h0000_8000, 32'h0002_0000, 32'h0000_0000, 32'd16);
      hold_rsp = 1'b1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      repeat (200) send_seg(random_seg());
      drain();
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.edge_start_x = '0;
      req_chan.edge_start_y = '0;
      req_chan.edge_dx      = '0;
      req_chan.edge_dy      = '0;
      req_chan.center_x     = '0;
      req_chan.center_y     = '0;
      req_chan.body_vel_x   = '0;
      req_chan.body_vel_y   = '0;
      req_chan.spin_rate    = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.index        = ewft_pkg::CSR_DRAG_GAIN;
      csr_chan.data         = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // first batch runs on reset register values
      repeat (4) send_seg(random_seg());
      drain();
      test_directed();
      test_register_sweep();
      test_backpressure();
      test_random_phases();

      $display("tb: %0d edges sent, %0d responses checked (%0d zero-length), %0d register writes",
               sent_count, checked_count, degen_count, csr_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: edge_wind_force_torque.f
hdl/ewft_pkg.sv
hdl/ewft_if.sv
hdl/ewft_delay.sv
hdl/ewft_fmul.sv
hdl/ewft_isqrt.sv
hdl/ewft_fdiv.sv
hdl/ewft_front.sv
hdl/ewft_back.sv
hdl/edge_wind_force_torque.sv
tb/tb_top.sv
